FILE: hdl/ttsg_pkg.sv
// constants, types and sine table for the two-tone sine generator
`timescale 1ns / 1ps
`default_nettype none

package ttsg_pkg;

    localparam int PHASE_WIDTH     = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_WIDTH      = 16;

    localparam int GAIN_W   = 16;
    localparam int STEP_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_AW   = 3;
    localparam int OUT_W    = 25;

    localparam int QTAB_N   = 1 << SINE_TABLE_BITS;
    localparam int MAG_W    = SINE_WIDTH - 1;
    localparam int PROD_W   = MAG_W + GAIN_W + 1;
    localparam int TONE_W   = PROD_W - 8 + 1;
    localparam int SUM_W    = (TONE_W + 1 > OUT_W + 1) ? TONE_W + 1 : OUT_W + 1;
    localparam int OUT_MAX  = 16777215;
    localparam int OUT_MIN  = -16777216;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_FS     = (64'd1 << (SINE_WIDTH - 1)) - 64'd1;

    localparam logic [CFG_AW-1:0] REG_GAIN_ONE       = 3'd0;
    localparam logic [CFG_AW-1:0] REG_GAIN_TWO       = 3'd1;
    localparam logic [CFG_AW-1:0] REG_PHASE_STEP_ONE = 3'd2;
    localparam logic [CFG_AW-1:0] REG_PHASE_STEP_TWO = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SAMPLE_COUNT   = 3'd4;

    typedef logic [PHASE_WIDTH-1:0]     t_phase;
    typedef logic [SINE_TABLE_BITS:0]   t_tab_idx;
    typedef logic [MAG_W-1:0]           t_mag;
    typedef logic signed [TONE_W-1:0]   t_tone;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef t_mag t_sine_rom [0:QTAB_N];

    // taylor series to x^13 in q30, every term truncated
    function automatic logic signed [63:0] sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        x2   = (x * x) >> 30;
        term = x;
        s    = signed'(x);
        for (int n = 2; n <= 12; n += 2) begin
            term = ((term * x2) >> 30) / 64'(n * (n + 1));
            if ((n & 2) != 0) begin
                s = s - signed'(term);
            end else begin
                s = s + signed'(term);
            end
        end
        return s;
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic signed [63:0] s;
        logic [63:0]        e;
        for (int k = 0; k <= QTAB_N; k++) begin
            x = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
            s = sine_q30(x);
            if (s < 0) begin
                s = 64'sd0;
            end
            e = (unsigned'(s) * SINE_FS + (64'd1 << 29)) >> 30;
            if (e > SINE_FS) begin
                e = SINE_FS;
            end
            rom[k] = e[MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: hdl/two_tone_sine_generator_core.sv
// two-tone sine generator: phase accumulators, table lookup, gain and sum pipeline
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_restart
//  result    out        o_valid / i_stall    o_sample_value, o_sample_index, o_last
//  config    in         i_cfg_wr_en          i_cfg_addr, i_cfg_wr_data
//
// one beat per clock while o_stall is low; a sample is registered in turn by the
// table read, the gain multiply, and the sum and output register
// a request beat that yields no sample only updates the run state
// o_stall rises only when every stage holds a sample and the output is stalled
// i_rst_n is synchronous; config, run state and valid registers come back to their listed reset values
`timescale 1ns / 1ps
`default_nettype none

module two_tone_sine_generator_core
    import ttsg_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_wr_en,
    input  wire [CFG_AW-1:0]         i_cfg_addr,
    input  wire [CFG_W-1:0]          i_cfg_wr_data,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  wire                      i_restart,
    output logic                     o_valid,
    input  wire                      i_stall,
    output logic signed [OUT_W-1:0]  o_sample_value,
    output logic [COUNT_W-1:0]       o_sample_index,
    output logic                     o_last
);

    localparam t_sum SUM_HI = SUM_W'(OUT_MAX);
    localparam t_sum SUM_LO = SUM_W'(OUT_MIN);

    // configuration
    logic [GAIN_W-1:0]  r_gain_one;
    logic [GAIN_W-1:0]  r_gain_two;
    logic [STEP_W-1:0]  r_step_one;
    logic [STEP_W-1:0]  r_step_two;
    logic [COUNT_W-1:0] r_sample_count;

    // run state
    t_phase             r_acc_one;
    t_phase             r_acc_two;
    logic [COUNT_W-1:0] r_next_index;
    logic               r_run_done;

    // stage 1: table read
    logic               r_v1;
    t_mag               r_mag_one;
    t_mag               r_mag_two;
    logic               r_neg_one_1;
    logic               r_neg_two_1;
    logic [COUNT_W-1:0] r_index_1;
    logic               r_last_1;

    // stage 2: scaled tones
    logic               r_v2;
    t_tone              r_tone_one;
    t_tone              r_tone_two;
    logic [COUNT_W-1:0] r_index_2;
    logic               r_last_2;

    // output register
    logic               r_ov;
    logic [OUT_W-1:0]   r_out_value;
    logic [COUNT_W-1:0] r_out_index;
    logic               r_out_last;

    logic ready_out;
    logic ready_2;
    logic ready_1;
    logic accept;

    assign ready_out = !r_ov || !i_stall;
    assign ready_2   = !r_v2 || ready_out;
    assign ready_1   = !r_v1 || ready_2;
    assign accept    = i_valid && ready_1;
    assign o_stall   = !ready_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_one     <= GAIN_W'(256);
            r_gain_two     <= GAIN_W'(256);
            r_step_one     <= '0;
            r_step_two     <= '0;
            r_sample_count <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_GAIN_ONE:       r_gain_one     <= i_cfg_wr_data[GAIN_W-1:0];
                REG_GAIN_TWO:       r_gain_two     <= i_cfg_wr_data[GAIN_W-1:0];
                REG_PHASE_STEP_ONE: r_step_one     <= i_cfg_wr_data[STEP_W-1:0];
                REG_PHASE_STEP_TWO: r_step_two     <= i_cfg_wr_data[STEP_W-1:0];
                REG_SAMPLE_COUNT:   r_sample_count <= i_cfg_wr_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // request decode against the current run state
    t_phase                   eff_acc_one;
    t_phase                   eff_acc_two;
    logic [COUNT_W-1:0]       eff_index;
    logic                     eff_done;
    logic                     emit;
    logic                     is_last;
    logic [COUNT_W:0]         index_inc;
    t_phase                   n_acc_one;
    t_phase                   n_acc_two;
    logic [COUNT_W-1:0]       n_next_index;
    logic                     n_run_done;
    logic [1:0]               quad_one;
    logic [1:0]               quad_two;
    logic [SINE_TABLE_BITS-1:0] k_one;
    logic [SINE_TABLE_BITS-1:0] k_two;
    t_tab_idx                 tab_idx_one;
    t_tab_idx                 tab_idx_two;

    always_comb begin
        eff_acc_one  = i_restart ? '0 : r_acc_one;
        eff_acc_two  = i_restart ? '0 : r_acc_two;
        eff_index    = i_restart ? '0 : r_next_index;
        eff_done     = i_restart ? 1'b0 : r_run_done;
        emit         = !eff_done && (eff_index < r_sample_count);
        index_inc    = {1'b0, eff_index} + (COUNT_W + 1)'(1);
        is_last      = index_inc == {1'b0, r_sample_count};
        n_acc_one    = emit ? eff_acc_one + PHASE_WIDTH'(r_step_one) : eff_acc_one;
        n_acc_two    = emit ? eff_acc_two + PHASE_WIDTH'(r_step_two) : eff_acc_two;
        n_next_index = emit ? index_inc[COUNT_W-1:0] : eff_index;
        n_run_done   = emit ? is_last : 1'b1;

        quad_one    = eff_acc_one[PHASE_WIDTH-1 -: 2];
        quad_two    = eff_acc_two[PHASE_WIDTH-1 -: 2];
        k_one       = eff_acc_one[PHASE_WIDTH-3 -: SINE_TABLE_BITS];
        k_two       = eff_acc_two[PHASE_WIDTH-3 -: SINE_TABLE_BITS];
        tab_idx_one = quad_one[0] ? t_tab_idx'(QTAB_N) - {1'b0, k_one} : {1'b0, k_one};
        tab_idx_two = quad_two[0] ? t_tab_idx'(QTAB_N) - {1'b0, k_two} : {1'b0, k_two};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_one    <= '0;
            r_acc_two    <= '0;
            r_next_index <= '0;
            r_run_done   <= 1'b1;
        end else if (accept) begin
            r_acc_one    <= n_acc_one;
            r_acc_two    <= n_acc_two;
            r_next_index <= n_next_index;
            r_run_done   <= n_run_done;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready_1) begin
            r_v1 <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_1) begin
            r_mag_one   <= SINE_ROM[tab_idx_one];
            r_mag_two   <= SINE_ROM[tab_idx_two];
            r_neg_one_1 <= quad_one[1];
            r_neg_two_1 <= quad_two[1];
            r_index_1   <= eff_index;
            r_last_1    <= is_last;
        end
    end

    // stage 2: magnitude times gain, rounded half away from zero at bit 8
    logic [PROD_W-1:0] prod_one;
    logic [PROD_W-1:0] prod_two;
    t_tone             mag_tone_one;
    t_tone             mag_tone_two;

    always_comb begin
        prod_one     = PROD_W'(r_mag_one) * PROD_W'(r_gain_one) + PROD_W'(128);
        prod_two     = PROD_W'(r_mag_two) * PROD_W'(r_gain_two) + PROD_W'(128);
        mag_tone_one = signed'({1'b0, prod_one[PROD_W-1:8]});
        mag_tone_two = signed'({1'b0, prod_two[PROD_W-1:8]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready_2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_2) begin
            r_tone_one <= r_neg_one_1 ? -mag_tone_one : mag_tone_one;
            r_tone_two <= r_neg_two_1 ? -mag_tone_two : mag_tone_two;
            r_index_2  <= r_index_1;
            r_last_2   <= r_last_1;
        end
    end

    // stage 3: sum and clamp into the output register
    t_sum sum;
    t_sum sum_sat;

    always_comb begin
        sum = SUM_W'(r_tone_one) + SUM_W'(r_tone_two);
        if (sum > SUM_HI) begin
            sum_sat = SUM_HI;
        end else if (sum < SUM_LO) begin
            sum_sat = SUM_LO;
        end else begin
            sum_sat = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ready_out) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_out) begin
            r_out_value <= sum_sat[OUT_W-1:0];
            r_out_index <= r_index_2;
            r_out_last  <= r_last_2;
        end
    end

    assign o_valid        = r_ov;
    assign o_sample_value = signed'(r_out_value);
    assign o_sample_index = r_out_index;
    assign o_last         = r_out_last;

endmodule

`default_nettype wire
